FILE: rtl/ipd_pkg.sv
// Shared constants, register codes and the score threshold function for the peak detector.
package ipd_pkg;

	localparam int ACCEL_W    = 16;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int ACC_W      = 32;
	localparam int SCORE_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KICK_THR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MS     = 3'd4;

	localparam logic [LEVEL_W-1:0] RST_ACTIVITY_THR = 16'd1229;
	localparam logic [LEVEL_W-1:0] RST_KICK_THR     = 16'd5120;
	localparam logic [LEVEL_W-1:0] RST_WINDOW_MS    = 16'd300;
	localparam logic [LEVEL_W-1:0] RST_COOLDOWN_MS  = 16'd1000;
	localparam logic [TIME_W-1:0]  RST_SLEEP_MS     = 32'd300000;

	localparam logic [LEVEL_W-1:0] ONE_G      = 16'd1024;
	localparam logic [LEVEL_W-1:0] PEAK_CLAMP = 16'd24576;
	localparam int                 IDX_SHIFT  = 5;
	localparam int                 IDX_W      = LEVEL_W - IDX_SHIFT;

	localparam int                 SCORE_LEVELS = 100;
	localparam int                 LEVEL_IDX_W  = $clog2(SCORE_LEVELS);
	localparam logic [SCORE_W-1:0] SCORE_MAX    = 7'd99;

	localparam int BIG_W = 160;

	// Smallest index i in 0..depth with i^7 * 99^10 >= s^10 * depth^7.
	// Evaluated at elaboration only.
	function automatic int score_thr(input int depth, input int s);
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] p99;
		int lo;
		int hi;
		int mid;
		lhs = BIG_W'(1);
		p99 = BIG_W'(1);
		for (int k = 0; k < 10; k++) begin
			lhs = lhs * BIG_W'(s);
			p99 = p99 * BIG_W'(99);
		end
		for (int k = 0; k < 7; k++) begin
			lhs = lhs * BIG_W'(depth);
		end
		lo = 0;
		hi = depth;
		for (int it = 0; it < 16; it++) begin
			if (lo < hi) begin
				mid = (lo + hi) >> 1;
				rhs = p99;
				for (int k = 0; k < 7; k++) begin
					rhs = rhs * BIG_W'(mid);
				end
				if (rhs >= lhs) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
		end
		return lo;
	endfunction

endpackage

FILE: rtl/ipd_mag.sv
// Deviation unit: sum of squares on one multiplier, then a bit-pair square root.
module ipd_mag (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ipd_pkg::ACCEL_W-1:0]    accel_x,
	input  logic signed [ipd_pkg::ACCEL_W-1:0]    accel_y,
	input  logic signed [ipd_pkg::ACCEL_W-1:0]    accel_z,
	output logic                                  done,
	output logic        [ipd_pkg::LEVEL_W-1:0]    dev
);

	localparam logic [1:0] P_IDLE   = 2'd0;
	localparam logic [1:0] P_SQUARE = 2'd1;
	localparam logic [1:0] P_ROOT   = 2'd2;
	localparam logic [1:0] P_DEV    = 2'd3;

	localparam int ACC_W   = ipd_pkg::ACC_W;
	localparam int STEP_W  = $clog2(ACC_W / 2);

	logic [1:0]                    phase_q;
	logic [1:0]                    axis_q;
	logic [STEP_W-1:0]             step_q;
	logic [ACC_W-1:0]              acc_q;
	logic [ACC_W-1:0]              rem_q;
	logic [ACC_W-1:0]              res_q;
	logic [ipd_pkg::LEVEL_W-1:0]   dev_q;
	logic                          done_q;

	logic signed [ipd_pkg::ACCEL_W-1:0] axis_val;
	logic [ipd_pkg::ACCEL_W-1:0]        axis_abs;
	logic [ACC_W-1:0]                   square;
	logic [ACC_W-1:0]                   acc_sum;
	logic [ACC_W-1:0]                   bit_val;
	logic [ACC_W-1:0]                   trial;
	logic                               take;
	logic [ipd_pkg::LEVEL_W-1:0]        mag;

	always_comb begin
		case (axis_q)
			2'd0:    axis_val = accel_x;
			2'd1:    axis_val = accel_y;
			default: axis_val = accel_z;
		endcase
	end

	// most negative input maps to 0x8000, which is its magnitude
	assign axis_abs = axis_val[ipd_pkg::ACCEL_W-1] ? ipd_pkg::ACCEL_W'(-axis_val)
		: ipd_pkg::ACCEL_W'(axis_val);
	assign square   = ACC_W'(axis_abs) * ACC_W'(axis_abs);
	assign acc_sum  = acc_q + square;

	assign bit_val = ACC_W'(1) << {step_q, 1'b0};
	assign trial   = res_q + bit_val;
	assign take    = rem_q >= trial;
	assign mag     = res_q[ipd_pkg::LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			axis_q  <= 2'd0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_SQUARE;
						axis_q  <= 2'd0;
					end
				end
				P_SQUARE: begin
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd2) begin
						phase_q <= P_ROOT;
						step_q  <= '1;
					end
				end
				P_ROOT: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						phase_q <= P_DEV;
					end
				end
				P_DEV: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				acc_q <= '0;
			end
			P_SQUARE: begin
				acc_q <= acc_sum;
				if (axis_q == 2'd2) begin
					rem_q <= acc_sum;
					res_q <= '0;
				end
			end
			P_ROOT: begin
				if (take) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_val;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			default: begin
				dev_q <= (mag >= ipd_pkg::ONE_G) ? mag - ipd_pkg::ONE_G : ipd_pkg::ONE_G - mag;
			end
		endcase
	end

	assign done = done_q;
	assign dev  = dev_q;

endmodule

FILE: rtl/ipd_score.sv
// Score unit: binary search of the peak index over a table of score thresholds.
module ipd_score #(
	parameter int SCORE_ROM_DEPTH = 768
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ipd_pkg::LEVEL_W-1:0]         peak,
	output logic                                done,
	output logic [ipd_pkg::SCORE_W-1:0]         score
);

	localparam int THR_W = $clog2(SCORE_ROM_DEPTH + 1);
	localparam int CMP_W = (THR_W > ipd_pkg::IDX_W) ? THR_W : ipd_pkg::IDX_W;

	logic [CMP_W-1:0] thr_tab [ipd_pkg::SCORE_LEVELS];

	for (genvar g = 0; g < ipd_pkg::SCORE_LEVELS; g++) begin : g_thr
		localparam int THR = ipd_pkg::score_thr(SCORE_ROM_DEPTH, g);
		assign thr_tab[g] = CMP_W'(THR);
	end

	logic                          busy_q;
	logic                          done_q;
	logic [ipd_pkg::SCORE_W-1:0]   lo_q;
	logic [ipd_pkg::SCORE_W-1:0]   hi_q;
	logic [CMP_W-1:0]              idx_q;

	logic [ipd_pkg::LEVEL_W-1:0]   peak_clamp;
	logic [CMP_W-1:0]              idx_raw;
	logic [CMP_W-1:0]              idx_cap;
	logic [ipd_pkg::SCORE_W:0]     mid_sum;
	logic [ipd_pkg::SCORE_W-1:0]   mid;

	assign peak_clamp = (peak > ipd_pkg::PEAK_CLAMP) ? ipd_pkg::PEAK_CLAMP : peak;
	assign idx_raw    = CMP_W'(peak_clamp >> ipd_pkg::IDX_SHIFT);
	assign idx_cap    = (idx_raw > CMP_W'(SCORE_ROM_DEPTH)) ? CMP_W'(SCORE_ROM_DEPTH) : idx_raw;
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q} + (ipd_pkg::SCORE_W + 1)'(1);
	assign mid        = mid_sum[ipd_pkg::SCORE_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && lo_q == hi_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lo_q  <= '0;
			hi_q  <= ipd_pkg::SCORE_MAX;
			idx_q <= idx_cap;
		end else if (busy_q && lo_q != hi_q) begin
			if (thr_tab[mid[ipd_pkg::LEVEL_IDX_W-1:0]] <= idx_q) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - ipd_pkg::SCORE_W'(1);
			end
		end
	end

	assign done  = done_q;
	assign score = lo_q;

endmodule

FILE: rtl/impact_peak_detector_core.sv
// Top level of the impact peak detector: sequencer, tracking state and result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid, in_ready  | action, accel_x, accel_y, accel_z, time_ms
//  out     | out_valid, out_ready| score_valid, kick_score, best/second/third_peak,
//          |                     | sleep_request
//  cfg     | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// A sample passes from accept to result register through a start step, the multiply-
// accumulate of the squares, the root iterations, the deviation and the sequencer steps.
// A closing kick window adds the score search. A clear beat goes straight to the finish
// state, which loads the result register once the output register is free.
// Reset sets the registers to their defaults and empties all tracking state.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register and the next beat is taken meanwhile. cfg_ready stays high.
module impact_peak_detector_core #(
	parameter int SCORE_ROM_DEPTH = 768
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic signed [ipd_pkg::ACCEL_W-1:0]     accel_x,
	input  logic signed [ipd_pkg::ACCEL_W-1:0]     accel_y,
	input  logic signed [ipd_pkg::ACCEL_W-1:0]     accel_z,
	input  logic        [ipd_pkg::TIME_W-1:0]      time_ms,

	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   score_valid,
	output logic        [ipd_pkg::SCORE_W-1:0]     kick_score,
	output logic        [ipd_pkg::LEVEL_W-1:0]     best_peak,
	output logic        [ipd_pkg::LEVEL_W-1:0]     second_peak,
	output logic        [ipd_pkg::LEVEL_W-1:0]     third_peak,
	output logic                                   sleep_request,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [ipd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [ipd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAG   = 3'd1;
	localparam logic [2:0] S_ACT   = 3'd2;
	localparam logic [2:0] S_SLP   = 3'd3;
	localparam logic [2:0] S_KICK  = 3'd4;
	localparam logic [2:0] S_CLOSE = 3'd5;
	localparam logic [2:0] S_SCORE = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	localparam int TW = ipd_pkg::TIME_W;
	localparam int LW = ipd_pkg::LEVEL_W;

	logic [2:0]     state_q;

	logic [LW-1:0]  act_thr_q;
	logic [LW-1:0]  kick_thr_q;
	logic [LW-1:0]  window_ms_q;
	logic [LW-1:0]  cooldown_ms_q;
	logic [TW-1:0]  sleep_ms_q;

	logic [LW-1:0]  best_q;
	logic [LW-1:0]  second_q;
	logic [LW-1:0]  third_q;
	logic           in_win_q;
	logic [LW-1:0]  win_peak_q;
	logic [TW-1:0]  win_start_q;
	logic [TW-1:0]  cd_end_q;
	logic           cd_active_q;
	logic [TW-1:0]  last_act_q;

	logic signed [ipd_pkg::ACCEL_W-1:0] x_q;
	logic signed [ipd_pkg::ACCEL_W-1:0] y_q;
	logic signed [ipd_pkg::ACCEL_W-1:0] z_q;
	logic [TW-1:0]  t_q;
	logic           mag_go_q;
	logic           cooling_q;
	logic           sleep_q;
	logic           close_q;

	logic                         out_valid_q;
	logic                         score_valid_q;
	logic [ipd_pkg::SCORE_W-1:0]  kick_score_q;
	logic [LW-1:0]                best_out_q;
	logic [LW-1:0]                second_out_q;
	logic [LW-1:0]                third_out_q;
	logic                         sleep_out_q;

	logic                         in_fire;
	logic                         mag_done;
	logic [LW-1:0]                dev;
	logic                         score_start;
	logic                         score_done;
	logic [ipd_pkg::SCORE_W-1:0]  score;
	logic                         out_free;
	logic [TW-1:0]                idle_time;
	logic [TW-1:0]                cd_diff;
	logic [TW-1:0]                win_time;
	logic                         win_over;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign idle_time = t_q - last_act_q;
	assign cd_diff   = t_q - cd_end_q;
	assign win_time  = t_q - win_start_q;
	assign win_over  = win_time > TW'(window_ms_q);
	assign score_start = (state_q == S_CLOSE) && !cooling_q && in_win_q && win_over;

	ipd_mag u_mag (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mag_go_q),
		.accel_x (x_q),
		.accel_y (y_q),
		.accel_z (z_q),
		.done    (mag_done),
		.dev     (dev)
	);

	ipd_score #(
		.SCORE_ROM_DEPTH (SCORE_ROM_DEPTH)
	) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (score_start),
		.peak   (win_peak_q),
		.done   (score_done),
		.score  (score)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_thr_q     <= ipd_pkg::RST_ACTIVITY_THR;
			kick_thr_q    <= ipd_pkg::RST_KICK_THR;
			window_ms_q   <= ipd_pkg::RST_WINDOW_MS;
			cooldown_ms_q <= ipd_pkg::RST_COOLDOWN_MS;
			sleep_ms_q    <= ipd_pkg::RST_SLEEP_MS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ipd_pkg::REG_ACTIVITY_THR: act_thr_q     <= cfg_data[LW-1:0];
				ipd_pkg::REG_KICK_THR:     kick_thr_q    <= cfg_data[LW-1:0];
				ipd_pkg::REG_WINDOW_MS:    window_ms_q   <= cfg_data[LW-1:0];
				ipd_pkg::REG_COOLDOWN_MS:  cooldown_ms_q <= cfg_data[LW-1:0];
				ipd_pkg::REG_SLEEP_MS:     sleep_ms_q    <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// capture the sample
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= accel_x;
			y_q <= accel_y;
			z_q <= accel_z;
			t_q <= time_ms;
		end
	end

	// sequencer and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mag_go_q    <= 1'b0;
			best_q      <= '0;
			second_q    <= '0;
			third_q     <= '0;
			in_win_q    <= 1'b0;
			win_peak_q  <= '0;
			win_start_q <= '0;
			cd_end_q    <= '0;
			cd_active_q <= 1'b0;
			last_act_q  <= '0;
			cooling_q   <= 1'b0;
			sleep_q     <= 1'b0;
			close_q     <= 1'b0;
		end else begin
			mag_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sleep_q <= 1'b0;
						close_q <= 1'b0;
						if (action) begin
							best_q   <= '0;
							second_q <= '0;
							third_q  <= '0;
							state_q  <= S_FIN;
						end else begin
							mag_go_q <= 1'b1;
							state_q  <= S_MAG;
						end
					end
				end
				S_MAG: begin
					if (mag_done) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (dev > act_thr_q) begin
						last_act_q <= t_q;
					end
					state_q <= S_SLP;
				end
				S_SLP: begin
					sleep_q   <= idle_time > sleep_ms_q;
					cooling_q <= cd_active_q && cd_diff[TW-1];
					state_q   <= S_KICK;
				end
				S_KICK: begin
					if (!cooling_q) begin
						cd_active_q <= 1'b0;
						if (!in_win_q && dev > kick_thr_q) begin
							in_win_q    <= 1'b1;
							win_start_q <= t_q;
							win_peak_q  <= dev;
						end else if (in_win_q && dev > win_peak_q) begin
							win_peak_q <= dev;
						end
					end
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (score_start) begin
						// insert below any equal entry, drop at or below third
						if (win_peak_q > best_q) begin
							third_q  <= second_q;
							second_q <= best_q;
							best_q   <= win_peak_q;
						end else if (win_peak_q > second_q) begin
							third_q  <= second_q;
							second_q <= win_peak_q;
						end else if (win_peak_q > third_q) begin
							third_q <= win_peak_q;
						end
						in_win_q    <= 1'b0;
						win_peak_q  <= '0;
						cd_end_q    <= t_q + TW'(cooldown_ms_q);
						cd_active_q <= 1'b1;
						close_q     <= 1'b1;
						state_q     <= S_SCORE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCORE: begin
					if (score_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			score_valid_q <= close_q;
			kick_score_q  <= close_q ? score : '0;
			best_out_q    <= best_q;
			second_out_q  <= second_q;
			third_out_q   <= third_q;
			sleep_out_q   <= sleep_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign score_valid   = score_valid_q;
	assign kick_score    = kick_score_q;
	assign best_peak     = best_out_q;
	assign second_peak   = second_out_q;
	assign third_peak    = third_out_q;
	assign sleep_request = sleep_out_q;

endmodule
